// File: rtl/smceg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smceg_pkg
// Types, codes and constants of the softmax cross-entropy gradient unit.
// ----------------------------------------------------------------------------
package smceg_pkg;

    localparam int MAX_CLASSES = 4096;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic KIND_LOSS = 1'b0;
    localparam logic KIND_GRAD = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOVEC = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] logit;
        logic               is_last;
        logic signed [15:0] target_index;
        logic [11:0]        read_index;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic [15:0]        loss;
        logic signed [15:0] gradient;
        logic               target_valid;
        logic [1:0]         status;
    } t_rsp;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] vv;
        res = 64'd0;
        bt  = 64'd1 << 62;
        vv  = v;
        for (int i = 0; i < 32; i++) begin
            if (bt > vv) bt = bt >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bt != 64'd0) begin
                if (vv >= res + bt) begin
                    vv  = vv - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q30
    function automatic logic [30:0] pow_c(input int k);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) begin
            if (i <= k) c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

    localparam logic [30:0] POW_TAB [17] = '{
        pow_c(0),  pow_c(1),  pow_c(2),  pow_c(3),  pow_c(4),  pow_c(5),
        pow_c(6),  pow_c(7),  pow_c(8),  pow_c(9),  pow_c(10), pow_c(11),
        pow_c(12), pow_c(13), pow_c(14), pow_c(15), pow_c(16)
    };

endpackage
`default_nettype wire

// File: rtl/softmax_cross_entropy_grad_unit.sv
`default_nettype none
// A push that is not last stores its logit. A last push runs one pass of
// the shared exp sequencer per stored class, then the restoring reciprocal,
// then the loss when the target is in range. A gradient read runs one exp
// pass; an early-status read answers without entering the sequencer.
// All multiplies share one 32x32 multiplier; the exp loop sets throughput.
// Reset is synchronous; the receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
// softmax_cross_entropy_grad_unit
// Stores logits, computes softmax normalizer, loss and per-class gradient.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_grad_unit
    import smceg_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_done,
    output t_rsp       o_rsp,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [15:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADDR = 4'd1;
    localparam logic [3:0] S_EXPT = 4'd2;
    localparam logic [3:0] S_EXPM = 4'd3;
    localparam logic [3:0] S_EXPR = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_LP32 = 4'd7;
    localparam logic [3:0] S_NORM = 4'd8;
    localparam logic [3:0] S_SQR  = 4'd9;
    localparam logic [3:0] S_LMUL = 4'd10;
    localparam logic [3:0] S_GRAD = 4'd11;

    localparam logic [1:0] MODE_SUM  = 2'd0;
    localparam logic [1:0] MODE_LOSS = 2'd1;
    localparam logic [1:0] MODE_GRAD = 2'd2;

    // logit store
    logic [15:0] r_mem [MAX_CLASSES];

    logic [3:0]         r_state;
    logic [1:0]         r_mode;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [15:0] r_max;
    logic [31:0]        r_sum;
    logic [31:0]        r_inv;
    logic signed [15:0] r_tgt;
    logic               r_rdy;
    logic [15:0]        r_cfg;
    logic [CNT_W-1:0]   r_i;
    logic [IDX_W-1:0]   r_ridx;
    logic [15:0]        r_rdata;
    logic [9:0]         r_n;
    logic [15:0]        r_f;
    logic [30:0]        r_a;
    logic [3:0]         r_j;
    logic [16:0]        r_e;
    logic [32:0]        r_rem;
    logic [31:0]        r_q;
    logic [5:0]         r_dc;
    logic [33:0]        r_val;
    logic [5:0]         r_k;
    logic [30:0]        r_m;
    logic [15:0]        r_fr;
    logic               r_done;
    t_rsp               r_rsp;

    logic               w_acc;
    logic [CNT_W-1:0]   w_ecnt;
    logic signed [15:0] w_emax;
    logic               w_we;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_tok;
    logic               w_tmatch;
    logic [31:0]        w_ma;
    logic [31:0]        w_mb;
    logic [63:0]        w_prod;
    logic [15:0]        w_d;
    logic [5:0]         w_s;
    logic [40:0]        w_rnd;
    logic [40:0]        w_ev;
    logic [32:0]        w_add;
    logic [32:0]        w_rem2;
    logic               w_ge;
    logic [33:0]        w_p32;
    logic [31:0]        w_sq;
    logic [21:0]        w_l2;
    logic [37:0]        w_lprod;
    logic [16:0]        w_lossv;
    logic [16:0]        w_g0;
    logic signed [17:0] w_g;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    assign w_acc  = start && !busy;
    // a push after a finished vector starts a new one
    assign w_ecnt = r_rdy ? '0 : r_cnt;
    assign w_emax = r_rdy ? -16'sd32768 : r_max;
    assign w_we   = w_acc && (i_req.req_type == REQ_PUSH) && !w_ecnt[CNT_W-1];

    assign w_tok    = !r_tgt[15] && ($unsigned(r_tgt) < 16'(r_cnt));
    assign w_tmatch = !r_tgt[15] && ($unsigned(r_tgt) == 16'(r_ridx));

    always_comb begin
        case (r_mode)
            MODE_SUM:  w_raddr = r_i[IDX_W-1:0];
            MODE_LOSS: w_raddr = r_tgt[IDX_W-1:0];
            default:   w_raddr = r_ridx;
        endcase
    end

    // shared multiplier operand select
    assign w_d = 16'(r_max - $signed(r_rdata));
    always_comb begin
        case (r_state)
            S_EXPT:  begin w_ma = 32'(w_d);   w_mb = 32'(LOG2E_Q16);           end
            S_EXPM:  begin w_ma = 32'(r_a);   w_mb = 32'(POW_TAB[5'd16 - 5'(r_j)]); end
            S_SQR:   begin w_ma = 32'(r_m);   w_mb = 32'(r_m);                 end
            S_LMUL:  begin w_ma = 32'(w_l2);  w_mb = 32'(LN2_Q16);             end
            default: begin w_ma = 32'(r_e);   w_mb = r_inv;                    end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // exp rounding shift, s = 14 + n, valid while n <= 26
    assign w_s   = 6'd14 + 6'(r_n[4:0]);
    assign w_rnd = 41'd1 << (w_s - 6'd1);
    assign w_ev  = (41'(r_a) + w_rnd) >> w_s;

    assign w_add  = {1'b0, r_sum} + 33'(r_e);
    assign w_rem2 = {r_rem[31:0], (r_dc == 6'd47)};
    assign w_ge   = (w_rem2 >= {1'b0, r_sum});

    assign w_p32   = (w_prod[48:15] == 34'd0) ? 34'd1 : w_prod[48:15];
    assign w_sq    = w_prod[61:30];
    assign w_l2    = 22'h200000 - ({r_k, 16'b0} + 22'(r_fr));
    assign w_lprod = w_prod[37:0] + 38'h100000;
    assign w_lossv = w_lprod[37:21];
    assign w_g0    = 17'((w_prod[48:0] + 49'h80000000) >> 32);
    assign w_g     = $signed({1'b0, w_g0}) - (w_tmatch ? 18'sd32768 : 18'sd0);

    // store: write on push, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_ecnt[IDX_W-1:0]] <= i_req.logit;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_SUM;
            r_cnt   <= '0;
            r_max   <= -16'sd32768;
            r_sum   <= '0;
            r_inv   <= '0;
            r_tgt   <= '0;
            r_rdy   <= 1'b0;
            r_cfg   <= 16'd40960;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_req.req_type == REQ_PUSH) begin
                        r_rdy <= 1'b0;
                        if (w_we) begin
                            r_cnt <= w_ecnt + 1'b1;
                            r_max <= (i_req.logit > w_emax) ? i_req.logit : w_emax;
                        end else begin
                            r_cnt <= w_ecnt;
                            r_max <= w_emax;
                        end
                        if (i_req.is_last) begin
                            r_tgt   <= i_req.target_index;
                            r_sum   <= '0;
                            r_i     <= '0;
                            r_mode  <= MODE_SUM;
                            r_state <= S_ADDR;
                        end
                    end else if (w_acc) begin
                        r_rsp.kind         <= KIND_GRAD;
                        r_rsp.loss         <= '0;
                        r_rsp.gradient     <= '0;
                        r_rsp.target_valid <= 1'b0;
                        if (!r_rdy) begin
                            r_rsp.status <= ST_NOVEC;
                            r_done       <= 1'b1;
                        end else if (13'(i_req.read_index) >= r_cnt) begin
                            r_rsp.status       <= ST_RANGE;
                            r_rsp.target_valid <= w_tok;
                            r_done             <= 1'b1;
                        end else begin
                            r_ridx  <= i_req.read_index;
                            r_mode  <= MODE_GRAD;
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_ADDR: r_state <= S_EXPT;
                S_EXPT: begin
                    r_n     <= w_prod[33:24];
                    r_f     <= w_prod[23:8];
                    r_a     <= 31'h40000000;
                    r_j     <= 4'd15;
                    r_state <= S_EXPM;
                end
                S_EXPM: begin
                    if (r_f[r_j]) r_a <= w_prod[60:30];
                    if (r_j == 4'd0) r_state <= S_EXPR;
                    else r_j <= r_j - 4'd1;
                end
                S_EXPR: begin
                    r_e <= (r_n > 10'd26) ? 17'd0 : w_ev[16:0];
                    case (r_mode)
                        MODE_SUM:  r_state <= S_ACC;
                        MODE_LOSS: r_state <= S_LP32;
                        default:   r_state <= S_GRAD;
                    endcase
                end
                S_ACC: begin
                    r_sum <= w_add[32] ? 32'hFFFFFFFF : w_add[31:0];
                    if (r_i + 1'b1 == r_cnt) begin
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_dc    <= 6'd47;
                        r_state <= S_DIV;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                S_DIV: begin
                    // restoring divide of 2^47 by the sum, one bit a cycle
                    r_rem <= w_ge ? (w_rem2 - {1'b0, r_sum}) : w_rem2;
                    r_q   <= {r_q[30:0], w_ge};
                    if (r_dc == 6'd0) begin
                        r_inv <= {r_q[30:0], w_ge};
                        r_rdy <= 1'b1;
                        if (w_tok) begin
                            r_mode  <= MODE_LOSS;
                            r_state <= S_ADDR;
                        end else begin
                            r_rsp.kind         <= KIND_LOSS;
                            r_rsp.loss         <= r_cfg;
                            r_rsp.gradient     <= '0;
                            r_rsp.target_valid <= 1'b0;
                            r_rsp.status       <= ST_OK;
                            r_done             <= 1'b1;
                            r_state            <= S_IDLE;
                        end
                    end else begin
                        r_dc <= r_dc - 6'd1;
                    end
                end
                S_LP32: begin
                    r_val   <= w_p32;
                    r_k     <= 6'd33;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // advance the leading one to the top bit
                    if (r_val[33]) begin
                        r_m     <= r_val[33:3];
                        r_fr    <= '0;
                        r_j     <= 4'd15;
                        r_state <= S_SQR;
                    end else begin
                        r_val <= {r_val[32:0], 1'b0};
                        r_k   <= r_k - 6'd1;
                    end
                end
                S_SQR: begin
                    r_m  <= w_sq[31] ? w_sq[31:1] : w_sq[30:0];
                    r_fr <= {r_fr[14:0], w_sq[31]};
                    if (r_j == 4'd0) r_state <= S_LMUL;
                    else r_j <= r_j - 4'd1;
                end
                S_LMUL: begin
                    r_rsp.kind         <= KIND_LOSS;
                    r_rsp.loss         <= w_lossv[16] ? 16'hFFFF : w_lossv[15:0];
                    r_rsp.gradient     <= '0;
                    r_rsp.target_valid <= 1'b1;
                    r_rsp.status       <= ST_OK;
                    r_done             <= 1'b1;
                    r_state            <= S_IDLE;
                end
                S_GRAD: begin
                    r_rsp.kind         <= KIND_GRAD;
                    r_rsp.loss         <= '0;
                    r_rsp.target_valid <= w_tok;
                    r_rsp.status       <= ST_OK;
                    if (w_g > 18'sd32767) r_rsp.gradient <= 16'sd32767;
                    else if (w_g < -18'sd32768) r_rsp.gradient <= -16'sd32768;
                    else r_rsp.gradient <= w_g[15:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_loss_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.kind == KIND_LOSS |-> o_rsp.status == ST_OK)
        else $error("loss result with nonzero status");

    a_novec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status == ST_NOVEC |-> !o_rsp.target_valid && o_rsp.gradient == 16'sd0)
        else $error("no-vector read carries data");

    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQR |-> r_m[30])
        else $error("mantissa lost normalization");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(busy) || $past(start))
        else $error("result strobe without a transfer");

endmodule
`default_nettype wire

// File: tb/softmax_cross_entropy_grad_unit_tb.sv
// ----------------------------------------------------------------------------
// softmax_cross_entropy_grad_unit_tb
// Drives logit pushes and gradient reads through the command port, predicts
// every loss and gradient result with a fixed-point softmax model kept in the
// bench, and checks each strobed result in order against that prediction.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_grad_unit_tb;
    import smceg_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_req        i_req       = '0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        busy;
    logic        o_done;
    t_rsp        o_rsp;
    logic        o_cfg_ready;

    softmax_cross_entropy_grad_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Requests waiting to be driven and loss/gradient results still owed.
    t_req pending_reqs[$];
    t_rsp expected_rsps[$];

    int mismatches  = 0;
    int n_loss      = 0;
    int n_grad      = 0;
    int n_status    = 0;
    int n_bad_tgt   = 0;

    // Shadow state of the softmax unit.
    logic signed [15:0] logit_mem [MAX_CLASSES];
    int                 vec_len    = 0;
    logic signed [15:0] vec_peak   = -16'sd32768;
    logic [63:0]        recip_sum  = '0;
    logic signed [15:0] vec_target = '0;
    logic               vec_done   = 1'b0;
    logic [15:0]        bad_target_loss = 16'd40960;
    logic [63:0]        pow_q30 [17];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // exp(-d) for a Q8.8 distance below the peak, result in Q16.
    function automatic logic [63:0] exp_q16(input logic [15:0] d);
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] s;
        logic [15:0] f;
        t = 64'(d) * 64'(LOG2E_Q16);
        s = 14 + (t >> 24);
        f = t[23:8];
        a = 64'd1 << 30;
        for (int j = 15; j >= 0; j--)
            if (f[j]) a = (a * pow_q30[16 - j]) >> 30;
        if (s > 40) return 0;
        return (a + (64'd1 << (s - 1))) >> s;
    endfunction

    // -ln(p) in Q5.11 from an unnormalized Q16 exponential.
    function automatic logic [15:0] loss_q11(input logic [63:0] e);
        logic [63:0] p32;
        logic [63:0] m;
        logic [63:0] l2;
        logic [63:0] lv;
        int          k;
        logic [15:0] frac;
        p32 = (e * recip_sum) >> 15;
        if (p32 == 0) p32 = 1;
        k = 0;
        while (k < 63 && (p32 >> (k + 1)) != 0) k++;
        m = (k >= 30) ? (p32 >> (k - 30)) : (p32 << (30 - k));
        frac = 0;
        repeat (16) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        l2 = (64'd32 << 16) - ((64'(k) << 16) + 64'(frac));
        lv = (l2 * 64'(LN2_Q16) + (64'd1 << 20)) >> 21;
        return (lv > 65535) ? 16'hFFFF : lv[15:0];
    endfunction

    function automatic logic [15:0] dist_to_peak(input logic signed [15:0] v);
        int d;
        d = int'(vec_peak) - int'(v);
        return d[15:0];
    endfunction

    function automatic logic target_in_range();
        return vec_target >= 0 && int'(vec_target) < vec_len;
    endfunction

    // Advance the shadow state by one accepted request; queue its result.
    task automatic softmax_step(input t_req r);
        t_rsp        o;
        logic [63:0] sum;
        logic [63:0] e;
        longint      g;
        o = '0;
        if (r.req_type == REQ_PUSH) begin
            if (vec_done) begin
                vec_len  = 0;
                vec_peak = -16'sd32768;
                vec_done = 1'b0;
            end
            if (vec_len < MAX_CLASSES) begin
                logit_mem[vec_len] = r.logit;
                vec_len++;
                if (r.logit > vec_peak) vec_peak = r.logit;
            end
            if (!r.is_last) return;
            vec_target = r.target_index;
            sum = 0;
            for (int i = 0; i < vec_len; i++) begin
                sum = sum + exp_q16(dist_to_peak(logit_mem[i]));
                if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            end
            if (sum == 0) sum = 1;
            recip_sum = (64'd1 << 47) / sum;
            vec_done  = 1'b1;
            o.kind         = KIND_LOSS;
            o.status       = ST_OK;
            o.target_valid = target_in_range();
            o.loss = o.target_valid
                ? loss_q11(exp_q16(dist_to_peak(logit_mem[vec_target[11:0]])))
                : bad_target_loss;
        end else begin
            o.kind = KIND_GRAD;
            if (!vec_done) begin
                o.status = ST_NOVEC;
            end else begin
                o.target_valid = target_in_range();
                if (int'(r.read_index) >= vec_len) begin
                    o.status = ST_RANGE;
                end else begin
                    e = exp_q16(dist_to_peak(logit_mem[r.read_index]));
                    g = longint'((e * recip_sum + (64'd1 << 31)) >> 32);
                    if (vec_target >= 0 && int'(vec_target) == int'(r.read_index))
                        g = g - 32768;
                    if (g > 32767) g = 32767;
                    if (g < -32768) g = -32768;
                    o.gradient = g[15:0];
                    o.status   = ST_OK;
                end
            end
        end
        expected_rsps.push_back(o);
    endtask

    // ------------------------------------------------------------------
    // Monitor: check strobed results first, then predict the transfer
    // accepted at this edge (a result never belongs to the same edge's item).
    // ------------------------------------------------------------------
    logic took = 1'b0;

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_rsp);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.kind !== want.kind || o_rsp.loss !== want.loss
                    || o_rsp.gradient !== want.gradient
                    || o_rsp.target_valid !== want.target_valid
                    || o_rsp.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, o_rsp);
                end
                if (want.kind == KIND_LOSS) n_loss++;
                else if (want.status == ST_OK) n_grad++;
                else n_status++;
                if (want.kind == KIND_LOSS && !want.target_valid) n_bad_tgt++;
            end
        end
        took <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) softmax_step(i_req);
    end

    // ------------------------------------------------------------------
    // Driver: hold the request until transferred, then idle or advance.
    // ------------------------------------------------------------------
    int gap_left  = 0;
    int calm_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
                // Alternate idle stretches with back-to-back runs.
                if (calm_left > 0) begin
                    calm_left <= calm_left - 1;
                    gap_left  <= 0;
                end else begin
                    gap_left <= pick_gap();
                    if ($urandom_range(0, 49) == 0) calm_left <= $urandom_range(20, 80);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers: don't-care fields carry random bits.
    // ------------------------------------------------------------------
    task automatic add_push(input logic [15:0] lg, input logic last,
                            input logic [15:0] tgt);
        t_req r;
        r.req_type     = REQ_PUSH;
        r.logit        = lg;
        r.is_last      = last;
        r.target_index = last ? tgt : 16'($urandom);
        r.read_index   = 12'($urandom);
        pending_reqs.push_back(r);
    endtask

    task automatic add_read(input logic [11:0] idx);
        t_req r;
        r.req_type     = REQ_READ;
        r.logit        = 16'($urandom);
        r.is_last      = 1'($urandom);
        r.target_index = 16'($urandom);
        r.read_index   = idx;
        pending_reqs.push_back(r);
    endtask

    // One random vector of n classes followed by a few reads.
    task automatic add_vector(input int n);
        int          base;
        int          spread;
        int          v;
        logic [15:0] tgt;
        base   = $urandom_range(0, 65535) - 32768;
        spread = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(16, 2048);
        case ($urandom_range(0, 9))
            0:       tgt = 16'($urandom);
            1:       tgt = 16'(n);
            2:       tgt = 16'(-$urandom_range(1, 4));
            default: tgt = 16'($urandom_range(0, n - 1));
        endcase
        for (int i = 0; i < n; i++) begin
            v = (spread == 65535) ? int'($urandom_range(0, 65535)) - 32768
                                  : base + int'($urandom_range(0, spread)) - spread / 2;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            // Occasionally read before the vector is complete.
            if ($urandom_range(0, 29) == 0) add_read(12'($urandom));
            add_push(16'(v), i == n - 1, tgt);
        end
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 5) == 0) add_read(12'($urandom));
            else add_read(12'($urandom_range(0, n - 1)));
        end
    endtask

    task automatic add_random_phase(input int items);
        int n;
        int budget;
        budget = items;
        while (budget > 0) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            budget = budget - n - 3;
            add_vector(n);
        end
    endtask

    // Hold off until every transfer has drained and the unit is idle.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_loss_reg(input logic [15:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bad_target_loss = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        pow_q30[0] = 64'd1 << 29;
        for (int k = 1; k <= 16; k++) pow_q30[k] = int_sqrt(pow_q30[k - 1] << 30);

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: read with no vector, then extreme logits and targets.
        add_read(12'd0);
        add_read(12'hFFF);
        add_push(16'sh7FFF, 1'b0, 16'd0);
        add_push(16'sh8000, 1'b0, 16'd0);
        add_push(16'sh0000, 1'b1, 16'd1);
        add_read(12'd0);
        add_read(12'd1);
        add_read(12'd2);
        add_read(12'd3);
        add_read(12'hFFF);
        add_push(16'sh0100, 1'b1, 16'd0);          // single class
        add_read(12'd0);
        add_push(16'sh0000, 1'b0, 16'd0);
        add_push(16'sh0000, 1'b1, 16'sh8000);      // most negative target
        add_read(12'd1);
        add_push(16'sh1234, 1'b0, 16'd0);
        add_push(16'shEDCC, 1'b1, 16'sh7FFF);      // target far too large
        add_read(12'd0);
        add_push(16'sh0500, 1'b0, 16'd0);
        add_push(16'sh0400, 1'b1, 16'd2);          // target equal to class count
        add_read(12'd1);

        write_loss_reg(16'd0);
        add_random_phase(300);

        // One wide vector, then reads at both ends and past the end.
        write_loss_reg(16'hFFFF);
        for (int i = 0; i < 200; i++)
            add_push(16'($urandom_range(0, 4095)) - 16'd2048, i == 199, 16'd120);
        add_read(12'd0);
        add_read(12'd199);
        add_read(12'd4095);
        add_push(16'sh0000, 1'b1, 16'sh8000);      // new vector after a wide one
        add_read(12'd0);
        add_random_phase(350);

        write_loss_reg(16'($urandom));
        add_random_phase(400);

        wait_idle();
        repeat (200) @(posedge i_clk);

        $display("covered %0d loss results (%0d with a bad target), %0d gradients,",
                 n_loss, n_bad_tgt, n_grad);
        $display("%0d early or out-of-range reads, over four loss register settings",
                 n_status);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("softmax_cross_entropy_grad_unit_tb passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_rsps.size());
            $display("softmax_cross_entropy_grad_unit_tb failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d results outstanding", expected_rsps.size());
        $display("softmax_cross_entropy_grad_unit_tb failed");
        $finish;
    end

endmodule
